### hw/rtl/segment_intersection_macros.svh
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// checked only outside reset
`define SI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/si_pkg.sv
`default_nettype none
package si_pkg;

	// default coordinate width
	localparam int COORD_BITS_DEF = 16;

	// result status codes
	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_NO_HIT   = 2'd1,
		ST_PARALLEL = 2'd2
	} status_t;

endpackage
`default_nettype wire

### hw/rtl/segment_intersection.sv
`default_nettype none
// segment pair intersection, fully pipelined
// slave channel s_tvalid/s_tready/s_tdata: one request holds the four endpoints
// of segments A and B as signed COORD_BITS integers
// master channel m_tvalid/m_tready/m_tdata: one result per request, carrying
// a status (hit, no hit, parallel or collinear) and the rounded crossing point
// stages s1 to s8 feed the divider stages and then the output register;
// the restoring divider resolves one quotient bit per stage, which sets depth
// throughput: one request per cycle while m_tready stays high, results leave in request order
// each stage holds its item while the next one is full and stalled, so
// bubbles close up and requests are still taken while a result waits
// when m_tready stays low the pipeline fills and s_tready falls
// reset clears all valid bits; data registers are not reset
// cross_x and cross_y read zero unless the status is a hit
module segment_intersection #(
	parameter int COORD_BITS = si_pkg::COORD_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output      logic                                  s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  wire logic [8*COORD_BITS-1:0]               s_tdata,
	output      logic                                  m_tvalid,
	input  wire logic                                  m_tready,
	// status, cross_x, cross_y, zero fill
	output      logic [((2*COORD_BITS+2+7)/8)*8-1:0]   m_tdata
);
	import si_pkg::*;

	localparam int N     = COORD_BITS;
	localparam int A_W   = N + 1;
	localparam int X_W   = 2*N;
	localparam int C_W   = 2*N + 1;
	localparam int AB_W  = 2*N + 2;
	localparam int SD_W  = 2*N + 3;
	localparam int PP_W  = 2*N + 2;
	localparam int P_W   = 3*N + 2;
	localparam int NM_W  = 3*N + 3;
	localparam int W     = 3*N + 4;
	localparam int Q     = N + 1;
	localparam int RW    = W - Q;
	localparam int OUT_W = ((2*N+2+7)/8)*8;
	localparam int DIV0  = 8;
	localparam int NS    = DIV0 + Q + 1;
	localparam int OUTS  = NS - 1;

	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	// stage enables: a stage moves when empty or when the next one moves
	assign en[OUTS] = !v_q[OUTS] || m_tready;
	for (genvar k = 0; k < OUTS; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end
	assign s_tready = en[0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en[0]) begin
			v_q[0] <= s_tvalid;
		end
	end
	for (genvar k = 1; k < NS; k++) begin : g_v
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en[k]) begin
				v_q[k] <= v_q[k-1];
			end
		end
	end

	// s1: direction terms and endpoint cross products
	logic signed [N-1:0]   x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic signed [A_W-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [2*N-1:0] p21_s1, p12_s1, p43_s1, p34_s1;
	logic signed [N-1:0]   ix1, iy1, ix2, iy2, ix3, iy3, ix4, iy4;

	assign ix1 = s_tdata[0*N +: N];
	assign iy1 = s_tdata[1*N +: N];
	assign ix2 = s_tdata[2*N +: N];
	assign iy2 = s_tdata[3*N +: N];
	assign ix3 = s_tdata[4*N +: N];
	assign iy3 = s_tdata[5*N +: N];
	assign ix4 = s_tdata[6*N +: N];
	assign iy4 = s_tdata[7*N +: N];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x1_s1  <= ix1;
			y1_s1  <= iy1;
			x2_s1  <= ix2;
			y2_s1  <= iy2;
			x3_s1  <= ix3;
			y3_s1  <= iy3;
			x4_s1  <= ix4;
			y4_s1  <= iy4;
			a1_s1  <= A_W'(iy2) - A_W'(iy1);
			b1_s1  <= A_W'(ix1) - A_W'(ix2);
			a2_s1  <= A_W'(iy4) - A_W'(iy3);
			b2_s1  <= A_W'(ix3) - A_W'(ix4);
			p21_s1 <= X_W'(ix2) * X_W'(iy1);
			p12_s1 <= X_W'(ix1) * X_W'(iy2);
			p43_s1 <= X_W'(ix4) * X_W'(iy3);
			p34_s1 <= X_W'(ix3) * X_W'(iy4);
		end
	end

	// s2: line offsets, side products and denominator products
	logic signed [A_W-1:0]  a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [C_W-1:0]  c1_s2, c2_s2;
	logic signed [C_W-1:0]  ax3_s2, by3_s2, ax4_s2, by4_s2;
	logic signed [C_W-1:0]  ax1_s2, by1_s2, ax2_s2, by2_s2;
	logic signed [AB_W-1:0] a1b2_s2, a2b1_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a1_s2   <= a1_s1;
			b1_s2   <= b1_s1;
			a2_s2   <= a2_s1;
			b2_s2   <= b2_s1;
			c1_s2   <= C_W'(p21_s1) - C_W'(p12_s1);
			c2_s2   <= C_W'(p43_s1) - C_W'(p34_s1);
			ax3_s2  <= C_W'(a1_s1) * C_W'(x3_s1);
			by3_s2  <= C_W'(b1_s1) * C_W'(y3_s1);
			ax4_s2  <= C_W'(a1_s1) * C_W'(x4_s1);
			by4_s2  <= C_W'(b1_s1) * C_W'(y4_s1);
			ax1_s2  <= C_W'(a2_s1) * C_W'(x1_s1);
			by1_s2  <= C_W'(b2_s1) * C_W'(y1_s1);
			ax2_s2  <= C_W'(a2_s1) * C_W'(x2_s1);
			by2_s2  <= C_W'(b2_s1) * C_W'(y2_s1);
			a1b2_s2 <= AB_W'(a1_s1) * AB_W'(b2_s1);
			a2b1_s2 <= AB_W'(a2_s1) * AB_W'(b1_s1);
		end
	end

	// s3: side values and denominator
	logic signed [A_W-1:0]  a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [C_W-1:0]  c1_s3, c2_s3;
	logic signed [SD_W-1:0] u3_s3, u4_s3, u1_s3, u2_s3, den_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			a1_s3  <= a1_s2;
			b1_s3  <= b1_s2;
			a2_s3  <= a2_s2;
			b2_s3  <= b2_s2;
			c1_s3  <= c1_s2;
			c2_s3  <= c2_s2;
			u3_s3  <= SD_W'(ax3_s2) + SD_W'(by3_s2) + SD_W'(c1_s2);
			u4_s3  <= SD_W'(ax4_s2) + SD_W'(by4_s2) + SD_W'(c1_s2);
			u1_s3  <= SD_W'(ax1_s2) + SD_W'(by1_s2) + SD_W'(c2_s2);
			u2_s3  <= SD_W'(ax2_s2) + SD_W'(by2_s2) + SD_W'(c2_s2);
			den_s3 <= SD_W'(a1b2_s2) - SD_W'(a2b1_s2);
		end
	end

	// s4: status and split numerator partial products
	logic                   same_a, same_b;
	status_t                st_next;
	logic signed [A_W-1:0]  c1_hi, c1_lo, c2_hi, c2_lo;
	status_t                st_s4;
	logic signed [SD_W-1:0] den_s4;
	logic signed [PP_W-1:0] b1c2h_s4, b1c2l_s4, b2c1h_s4, b2c1l_s4;
	logic signed [PP_W-1:0] a2c1h_s4, a2c1l_s4, a1c2h_s4, a1c2l_s4;

	always_comb begin
		same_a = (u3_s3 != '0) && (u4_s3 != '0) && (u3_s3[SD_W-1] == u4_s3[SD_W-1]);
		same_b = (u1_s3 != '0) && (u2_s3 != '0) && (u1_s3[SD_W-1] == u2_s3[SD_W-1]);
		if (same_a || same_b) begin
			st_next = ST_NO_HIT;
		end else if (den_s3 == '0) begin
			st_next = ST_PARALLEL;
		end else begin
			st_next = ST_HIT;
		end
		c1_hi = $signed(c1_s3[C_W-1:N]);
		c1_lo = $signed({1'b0, c1_s3[N-1:0]});
		c2_hi = $signed(c2_s3[C_W-1:N]);
		c2_lo = $signed({1'b0, c2_s3[N-1:0]});
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			st_s4    <= st_next;
			den_s4   <= den_s3;
			b1c2h_s4 <= PP_W'(b1_s3) * PP_W'(c2_hi);
			b1c2l_s4 <= PP_W'(b1_s3) * PP_W'(c2_lo);
			b2c1h_s4 <= PP_W'(b2_s3) * PP_W'(c1_hi);
			b2c1l_s4 <= PP_W'(b2_s3) * PP_W'(c1_lo);
			a2c1h_s4 <= PP_W'(a2_s3) * PP_W'(c1_hi);
			a2c1l_s4 <= PP_W'(a2_s3) * PP_W'(c1_lo);
			a1c2h_s4 <= PP_W'(a1_s3) * PP_W'(c2_hi);
			a1c2l_s4 <= PP_W'(a1_s3) * PP_W'(c2_lo);
		end
	end

	// s5: full numerator products
	status_t                st_s5;
	logic signed [SD_W-1:0] den_s5;
	logic signed [P_W-1:0]  b1c2_s5, b2c1_s5, a2c1_s5, a1c2_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			st_s5   <= st_s4;
			den_s5  <= den_s4;
			b1c2_s5 <= (P_W'(b1c2h_s4) <<< N) + P_W'(b1c2l_s4);
			b2c1_s5 <= (P_W'(b2c1h_s4) <<< N) + P_W'(b2c1l_s4);
			a2c1_s5 <= (P_W'(a2c1h_s4) <<< N) + P_W'(a2c1l_s4);
			a1c2_s5 <= (P_W'(a1c2h_s4) <<< N) + P_W'(a1c2l_s4);
		end
	end

	// s6: numerators
	status_t                st_s6;
	logic signed [SD_W-1:0] den_s6;
	logic signed [NM_W-1:0] nx_s6, ny_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			st_s6  <= st_s5;
			den_s6 <= den_s5;
			nx_s6  <= NM_W'(b1c2_s5) - NM_W'(b2c1_s5);
			ny_s6  <= NM_W'(a2c1_s5) - NM_W'(a1c2_s5);
		end
	end

	// s7: magnitudes and result signs
	status_t         st_s7;
	logic [SD_W-1:0] dm_s7;
	logic [NM_W-1:0] mx_s7, my_s7;
	logic            sx_s7, sy_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			st_s7 <= st_s6;
			dm_s7 <= den_s6[SD_W-1] ? SD_W'(-den_s6) : SD_W'(den_s6);
			mx_s7 <= nx_s6[NM_W-1] ? NM_W'(-nx_s6) : NM_W'(nx_s6);
			my_s7 <= ny_s6[NM_W-1] ? NM_W'(-ny_s6) : NM_W'(ny_s6);
			sx_s7 <= nx_s6[NM_W-1] ^ den_s6[SD_W-1];
			sy_s7 <= ny_s6[NM_W-1] ^ den_s6[SD_W-1];
		end
	end

	// s8: rounding offset of half the denominator
	status_t         st_s8;
	logic [SD_W-1:0] dm_s8;
	logic [W-1:0]    mx_s8, my_s8;
	logic            sx_s8, sy_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			st_s8 <= st_s7;
			dm_s8 <= dm_s7;
			mx_s8 <= W'(mx_s7) + W'(dm_s7 >> 1);
			my_s8 <= W'(my_s7) + W'(dm_s7 >> 1);
			sx_s8 <= sx_s7;
			sy_s8 <= sy_s7;
		end
	end

	// restoring divider, one quotient bit per stage
	logic [RW-1:0] rem_x_s [0:Q];
	logic [RW-1:0] rem_y_s [0:Q];
	logic [Q-1:0]  low_x_s [0:Q];
	logic [Q-1:0]  low_y_s [0:Q];
	logic [Q-1:0]  quo_x_s [0:Q];
	logic [Q-1:0]  quo_y_s [0:Q];
	logic [RW-1:0] dm_d_s  [0:Q];
	logic          sx_d_s  [0:Q];
	logic          sy_d_s  [0:Q];
	status_t       st_d_s  [0:Q];

	assign rem_x_s[0] = mx_s8[W-1:Q];
	assign rem_y_s[0] = my_s8[W-1:Q];
	assign low_x_s[0] = mx_s8[Q-1:0];
	assign low_y_s[0] = my_s8[Q-1:0];
	assign quo_x_s[0] = '0;
	assign quo_y_s[0] = '0;
	assign dm_d_s[0]  = RW'(dm_s8);
	assign sx_d_s[0]  = sx_s8;
	assign sy_d_s[0]  = sy_s8;
	assign st_d_s[0]  = st_s8;

	for (genvar k = 0; k < Q; k++) begin : g_div
		logic [RW:0] tx, ty;
		logic        gex, gey;

		always_comb begin
			tx  = {rem_x_s[k], low_x_s[k][Q-1]};
			ty  = {rem_y_s[k], low_y_s[k][Q-1]};
			gex = tx >= {1'b0, dm_d_s[k]};
			gey = ty >= {1'b0, dm_d_s[k]};
		end

		always_ff @(posedge clk) begin
			if (en[DIV0+k]) begin
				rem_x_s[k+1] <= gex ? RW'(tx - {1'b0, dm_d_s[k]}) : RW'(tx);
				rem_y_s[k+1] <= gey ? RW'(ty - {1'b0, dm_d_s[k]}) : RW'(ty);
				low_x_s[k+1] <= low_x_s[k] << 1;
				low_y_s[k+1] <= low_y_s[k] << 1;
				quo_x_s[k+1] <= Q'({quo_x_s[k], gex});
				quo_y_s[k+1] <= Q'({quo_y_s[k], gey});
				dm_d_s[k+1]  <= dm_d_s[k];
				sx_d_s[k+1]  <= sx_d_s[k];
				sy_d_s[k+1]  <= sy_d_s[k];
				st_d_s[k+1]  <= st_d_s[k];
			end
		end
	end

	// output register: apply sign, zero the point unless a hit
	status_t      st_q;
	logic [N-1:0] cx_q, cy_q;
	logic [Q-1:0] qx_sgn, qy_sgn;

	always_comb begin
		qx_sgn = sx_d_s[Q] ? Q'(-quo_x_s[Q]) : quo_x_s[Q];
		qy_sgn = sy_d_s[Q] ? Q'(-quo_y_s[Q]) : quo_y_s[Q];
	end

	always_ff @(posedge clk) begin
		if (en[OUTS]) begin
			st_q <= st_d_s[Q];
			cx_q <= (st_d_s[Q] == ST_HIT) ? qx_sgn[N-1:0] : '0;
			cy_q <= (st_d_s[Q] == ST_HIT) ? qy_sgn[N-1:0] : '0;
		end
	end

	assign m_tvalid = v_q[OUTS];
	assign m_tdata  = OUT_W'({cy_q, cx_q, st_q});

endmodule
`default_nettype wire

### hw/rtl/si_checker.sv
`default_nettype none
`include "segment_intersection_macros.svh"
module si_checker #(
	parameter int COORD_BITS = si_pkg::COORD_BITS_DEF
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_tvalid,
	input wire logic                                s_tready,
	input wire logic [8*COORD_BITS-1:0]             s_tdata,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_tdata
);
	import si_pkg::*;

	localparam int N = COORD_BITS;

	logic [1:0] st_c;

	assign st_c = m_tdata[1:0];

	// a stalled result keeps its value
	`SI_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	// status is always a defined code
	`SI_ASSERT(a_code, m_tvalid |-> st_c == ST_HIT || st_c == ST_NO_HIT || st_c == ST_PARALLEL, "bad status code")

	// point fields are zero unless the segments meet
	`SI_ASSERT(a_zero, m_tvalid && st_c != ST_HIT |-> m_tdata[2*N+1:2] == '0, "point set without hit")

	// no result while reset is held
	`SI_ASSERT_ALWAYS(a_rst, !arst_n |-> !m_tvalid, "result valid in reset")

	// an accepted request carries known data
	`SI_ASSERT(a_known, s_tvalid && s_tready |-> !$isunknown(s_tdata), "unknown request data")

endmodule

bind segment_intersection si_checker #(.COORD_BITS(COORD_BITS)) u_si_checker (.*);
`default_nettype wire

### tb/segment_intersection_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module segment_intersection_checker #(
	parameter int COORD_BITS = si_pkg::COORD_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	input  wire logic                                s_tready,
	input  wire logic [8*COORD_BITS-1:0]             s_tdata,
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_tdata,
	output      int                                  errors,
	output      int                                  pending,
	output      int                                  hits,
	output      int                                  misses,
	output      int                                  parallels
);
	import si_pkg::*;

	typedef struct packed {
		status_t                       status;
		logic signed [COORD_BITS-1:0]  cross_x;
		logic signed [COORD_BITS-1:0]  cross_y;
	} crossing_t;

	crossing_t crossings_due[$];

	// product terms stay below 2^(4*COORD_BITS+4), 128 bits is ample
	typedef logic signed [127:0] wide_t;

	function automatic logic straddle_free(wide_t u, wide_t v);
		return u != 0 && v != 0 && ((u > 0) == (v > 0));
	endfunction

	// rounded quotient: add half the divisor magnitude to the numerator magnitude, truncate, apply the combined sign
	function automatic wide_t rounded_quotient(wide_t num, wide_t den);
		wide_t mag, dmag, q;
		mag  = (num < 0) ? -num : num;
		dmag = (den < 0) ? -den : den;
		q = (mag + (dmag >>> 1)) / dmag;
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic crossing_t predict_crossing(logic [8*COORD_BITS-1:0] d);
		wide_t p [8];
		wide_t a1, b1, c1, a2, b2, c2, den;
		crossing_t r;
		for (int i = 0; i < 8; i++)
			p[i] = wide_t'($signed(d[i*COORD_BITS +: COORD_BITS]));
		r = '0;
		r.status = ST_HIT;
		a1 = p[3] - p[1];
		b1 = p[0] - p[2];
		c1 = p[2] * p[1] - p[0] * p[3];
		a2 = p[7] - p[5];
		b2 = p[4] - p[6];
		c2 = p[6] * p[5] - p[4] * p[7];
		den = a1 * b2 - a2 * b1;
		if (straddle_free(a1*p[4] + b1*p[5] + c1, a1*p[6] + b1*p[7] + c1) ||
				straddle_free(a2*p[0] + b2*p[1] + c2, a2*p[2] + b2*p[3] + c2))
			r.status = ST_NO_HIT;
		else if (den == 0)
			r.status = ST_PARALLEL;
		else begin
			r.cross_x = COORD_BITS'(rounded_quotient(b1*c2 - b2*c1, den));
			r.cross_y = COORD_BITS'(rounded_quotient(a2*c1 - a1*c2, den));
		end
		return r;
	endfunction

	assign pending = crossings_due.size();

	// predict on each request, compare on each result
	always @(posedge clk) begin
		crossing_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				crossings_due = {crossings_due, predict_crossing(s_tdata)};
			if (m_tvalid && m_tready) begin
				got = crossing_t'({m_tdata[1:0], m_tdata[2 +: COORD_BITS],
					m_tdata[2+COORD_BITS +: COORD_BITS]});
				if (crossings_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", m_tdata);
				end else begin
					want = crossings_due.pop_front();
					case (want.status)
						ST_HIT:    hits++;
						ST_NO_HIT: misses++;
						default:   parallels++;
					endcase
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %s %0d %0d, got %0d %0d %0d",
								want.status.name(), want.cross_x, want.cross_y,
								got.status, got.cross_x, got.cross_y);
					end
				end
			end
		end
	end

	initial begin
		errors = 0;
		hits = 0;
		misses = 0;
		parallels = 0;
	end
endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import si_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int MW = ((2*CB+2+7)/8)*8;
	localparam int N_RANDOM = 1200;

	logic clk = 0, arst_n = 1;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
	logic [8*CB-1:0] s_tdata = '0;
	logic [MW-1:0] m_tdata;
	int errors, pending, hits, misses, parallels;
	logic stim_done = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	segment_intersection #(.COORD_BITS(CB)) dut (.*);

	segment_intersection_checker #(.COORD_BITS(CB)) checker_i (.*);

	function automatic logic [CB-1:0] rnd_coord(int span);
		if (span == 0)
			return CB'($urandom);
		return CB'($signed($urandom_range(2*span)) - span);
	endfunction

	// valid stays up between back to back requests
	task automatic send_request(logic [8*CB-1:0] d);
		int gap;
		gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
		if (gap != 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [8*CB-1:0] pack_pts(int v[8]);
		logic [8*CB-1:0] d;
		for (int i = 0; i < 8; i++)
			d[i*CB +: CB] = CB'(v[i]);
		return d;
	endfunction

	// receiver stall pattern, one drawn wait per result
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = ($urandom_range(4) == 0) ? 0 : $urandom_range(16);
			if (w != 0) begin
				m_tready <= 0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// stimulus: directed corners, then random mix
	initial begin
		int v[8];
		logic [8*CB-1:0] d;
		arst_n <= 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// crossing diagonals, touching ends, parallel, collinear, degenerate, extremes
		send_request(pack_pts('{-10, -10, 10, 10, -10, 10, 10, -10}));
		send_request(pack_pts('{0, 0, 10, 0, 10, 0, 10, 10}));
		send_request(pack_pts('{0, 0, 10, 0, 0, 5, 10, 5}));
		send_request(pack_pts('{0, 0, 10, 0, 5, 0, 20, 0}));
		send_request(pack_pts('{3, 3, 3, 3, 0, 0, 9, 9}));
		send_request(pack_pts('{0, 0, 10, 10, 20, 0, 30, 5}));
		send_request(pack_pts('{0, 0, 3, 1, 0, 1, 3, 0}));
		send_request(pack_pts('{0, 0, -3, 1, 0, 1, -3, 0}));
		send_request(pack_pts('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}));
		send_request(pack_pts('{-32768, 0, 32767, 0, 0, -32768, 0, 32767}));
		send_request(pack_pts('{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767}));
		send_request(pack_pts('{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768}));
		send_request(pack_pts('{-1, -1, -1, -1, -1, -1, -1, -1}));
		// hold until drained
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		for (int n = 0; n < N_RANDOM; n++) begin
			int span;
			span = (n % 3 == 0) ? 0 : ((n % 3 == 1) ? 50 : 2000);
			for (int i = 0; i < 8; i++)
				v[i] = $signed(rnd_coord(span));
			// force some parallel pairs
			if ($urandom_range(9) == 0) begin
				v[6] = v[4] + (v[2] - v[0]);
				v[7] = v[5] + (v[3] - v[1]);
				if (span == 0) begin
					v[6] = $signed(CB'(v[6]));
					v[7] = $signed(CB'(v[7]));
				end
			end
			d = pack_pts(v);
			send_request(d);
		end
		s_tvalid <= 0;
		stim_done = 1;
	end

	// verdict
	initial begin
		wait (stim_done);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d hits, %0d misses, %0d parallel or collinear pairs",
			hits, misses, parallels);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
